/* rtl/core/avcnal_pkg.sv */
// shared types and constants for the avc nal idr scanner
package avcnal_pkg;

  localparam int unsigned NAL_LEN_W_DEF   = 32;
  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned CFG_W           = 3;
  localparam int unsigned PREFIX_MAX      = 4;
  localparam int unsigned PREFIX_MIN      = 1;
  localparam int unsigned LEN_BYTES_RESET = 4;

  localparam logic [4:0] NAL_TYPE_IDR = 5'd5;

  typedef enum logic [1:0] {
    PH_LEN  = 2'd0,
    PH_HDR  = 2'd1,
    PH_BODY = 2'd2,
    PH_ERR  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TRUNC   = 2'd1,
    ST_BADSIZE = 2'd2
  } status_t;

endpackage

/* rtl/core/avcnal_ifs.sv */
// valid/ready channel interfaces for packet bytes and scan results
interface avcnal_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface avcnal_out_if;
  logic       valid;
  logic       ready;
  logic       idr_found;
  logic [1:0] scan_status;

  modport source (output valid, output idr_found, output scan_status, input ready);
  modport sink (input valid, input idr_found, input scan_status, output ready);
endinterface

/* rtl/core/avc_nal_idr_scanner.sv */
// Scans MP4 length-prefixed AVC packets one byte per cycle and reports, at the
// byte flagged last, whether any NAL header had type 5 (IDR) plus a status:
// ok, truncated length field or invalid NAL size. A byte is taken into an
// input register, the scan state is updated by one counter step and compare,
// and the packet result lands in an output register as the last byte leaves
// the input register. Throughput is one byte per cycle; the only stall comes
// from a held result when the next last byte needs the output register.
// The prefix length (cfg_wr_data, 1..4 bytes) should be written between packets.
module avc_nal_idr_scanner #(
  parameter int unsigned NAL_LENGTH_WIDTH = avcnal_pkg::NAL_LEN_W_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [avcnal_pkg::CFG_W-1:0]       cfg_wr_data,
  avcnal_in_if.sink                          in_ch,
  avcnal_out_if.source                       out_ch
);
  import avcnal_pkg::*;

  localparam int unsigned LW = NAL_LENGTH_WIDTH;

  logic              s1_v_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_last_r;
  logic              s1_go;

  logic [CFG_W-1:0]  len_bytes_r;
  logic [CFG_W-1:0]  eff_len;
  logic [CFG_W-1:0]  taken_inc;

  phase_t            phase_r, phase_nxt;
  logic [1:0]        taken_r, taken_nxt;
  logic [LW-1:0]     left_r, left_nxt;
  logic [LW+BYTE_W-1:0] shifted;
  logic [LW-1:0]     left_dec;
  logic              idr_r, idr_nxt;
  status_t           err_r, err_nxt;

  logic              out_v_r;
  logic              out_idr_r;
  status_t           out_status_r;

  // input register stage
  assign s1_go       = s1_v_r && (!s1_last_r || !out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_v_r <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_r <= in_ch.data_byte;
      s1_last_r <= in_ch.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_bytes_r <= CFG_W'(LEN_BYTES_RESET);
    end else if (cfg_wr_en) begin
      len_bytes_r <= cfg_wr_data;
    end
  end

  // out of range prefix lengths clamp to 1..4
  always_comb begin
    if (len_bytes_r < CFG_W'(PREFIX_MIN)) begin
      eff_len = CFG_W'(PREFIX_MIN);
    end else if (len_bytes_r > CFG_W'(PREFIX_MAX)) begin
      eff_len = CFG_W'(PREFIX_MAX);
    end else begin
      eff_len = len_bytes_r;
    end
  end

  assign taken_inc = {1'b0, taken_r} + CFG_W'(1);
  assign shifted   = {left_r, s1_byte_r};
  assign left_dec  = left_r - LW'(1);

  always_comb begin
    phase_nxt = phase_r;
    taken_nxt = taken_r;
    left_nxt  = left_r;
    idr_nxt   = idr_r;
    err_nxt   = err_r;
    case (phase_r)
      PH_LEN: begin
        left_nxt = shifted[LW-1:0];
        if (taken_inc >= eff_len) begin
          taken_nxt = 2'd0;
          if (shifted[LW-1:0] == '0 || s1_last_r) begin
            phase_nxt = PH_ERR;
            err_nxt   = ST_BADSIZE;
          end else begin
            phase_nxt = PH_HDR;
          end
        end else begin
          taken_nxt = taken_inc[1:0];
          if (s1_last_r) begin
            phase_nxt = PH_ERR;
            err_nxt   = ST_TRUNC;
          end
        end
      end
      PH_HDR, PH_BODY: begin
        if (phase_r == PH_HDR && s1_byte_r[4:0] == NAL_TYPE_IDR) begin
          idr_nxt = 1'b1;
        end
        left_nxt = left_dec;
        if (left_dec == '0) begin
          phase_nxt = PH_LEN;
        end else begin
          phase_nxt = PH_BODY;
          if (s1_last_r) begin
            phase_nxt = PH_ERR;
            err_nxt   = ST_BADSIZE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEN;
      taken_r <= 2'd0;
      left_r  <= '0;
      idr_r   <= 1'b0;
      err_r   <= ST_OK;
    end else if (s1_go) begin
      if (s1_last_r) begin
        phase_r <= PH_LEN;
        taken_r <= 2'd0;
        left_r  <= '0;
        idr_r   <= 1'b0;
        err_r   <= ST_OK;
      end else begin
        phase_r <= phase_nxt;
        taken_r <= taken_nxt;
        left_r  <= left_nxt;
        idr_r   <= idr_nxt;
        err_r   <= err_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_go && s1_last_r) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
    if (s1_go && s1_last_r) begin
      out_idr_r    <= (err_nxt == ST_OK) && idr_nxt;
      out_status_r <= err_nxt;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.idr_found   = out_idr_r;
  assign out_ch.scan_status = out_status_r;

  a_idr_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_idr_r |-> out_status_r == ST_OK)
    else $error("idr flag given with an error status");

  a_err_phase: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_ERR |-> err_r != ST_OK)
    else $error("error phase without a recorded error");

  a_body_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HDR || phase_r == PH_BODY |-> left_r != '0)
    else $error("nal body phase with no bytes left");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_last_r |=> out_v_r)
    else $error("last item gave no result");

endmodule
